@@ hw/rtl/dq_pkg.sv @@
`timescale 1ns / 1ps

package dq_pkg;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_FROM_LEFT  = 2'd1,
    CELL_FROM_RIGHT = 2'd2,
    CELL_LOAD       = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     is_tail;
  } cell_ctl_t;

endpackage

@@ hw/rtl/double_ended_queue.sv @@
`timescale 1ns / 1ps
// Latency: the result of a command is registered and appears with done in the cycle after start.
// Throughput: one command per cycle; a push or pop at the front shifts every cell, a push at the back loads one cell.
// busy stays low; the receiver cannot stall, so each result is shown for one cycle only.
// Reset: the entry count returns to zero and done clears; stored words stay undefined.

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    cmd,
  input  logic [31:0]                   data_in,
  output logic                          done,
  output logic [31:0]                   data_out,
  output logic [1:0]                    status,
  output logic [$clog2(CAPACITY+1)-1:0] entry_count,
  output logic                          is_empty
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  accept;
  logic                  is_full;
  logic                  no_entries;
  logic                  shift_right;
  logic                  shift_left;
  logic                  load_back;
  logic [DATA_WIDTH-1:0] word_in;
  logic [DATA_WIDTH-1:0] rd;
  logic [DATA_WIDTH-1:0] back_word;
  status_t               status_next;
  logic [63:0]           in_wide;
  logic [63:0]           rd_wide;

  logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
  logic [DATA_WIDTH-1:0] tail_word [CAPACITY];
  cell_ctl_t             cell_ctl  [CAPACITY];

  assign busy       = 1'b0;
  assign accept     = start && !busy;
  assign is_full    = (count == CNT_W'(CAPACITY));
  assign no_entries = (count == '0);
  assign in_wide    = {32'd0, data_in};
  assign word_in    = in_wide[DATA_WIDTH-1:0];

  always_comb begin
    back_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      back_word = back_word | tail_word[k];
    end
  end

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    rd          = '0;
    shift_right = 1'b0;
    shift_left  = 1'b0;
    load_back   = 1'b0;
    if (accept) begin
      unique case (cmd)
        CMD_PUSH_FRONT: begin
          if (is_full) begin
            status_next = ST_FULL;
          end else begin
            shift_right = 1'b1;
            count_next  = count + 1'b1;
          end
        end
        CMD_PUSH_BACK: begin
          if (is_full) begin
            status_next = ST_FULL;
          end else begin
            load_back  = 1'b1;
            count_next = count + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (no_entries) begin
            status_next = ST_EMPTY;
          end else begin
            rd         = cell_word[0];
            shift_left = 1'b1;
            count_next = count - 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (no_entries) begin
            status_next = ST_EMPTY;
          end else begin
            rd         = back_word;
            count_next = count - 1'b1;
          end
        end
        CMD_PEEK_FRONT: begin
          if (no_entries) begin
            status_next = ST_EMPTY;
          end else begin
            rd = cell_word[0];
          end
        end
        CMD_PEEK_BACK: begin
          if (no_entries) begin
            status_next = ST_EMPTY;
          end else begin
            rd = back_word;
          end
        end
        CMD_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  // cell 0 is the front of the queue
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_word;
    logic [DATA_WIDTH-1:0] right_word;

    if (i == 0) begin : g_first
      assign left_word = word_in;
    end else begin : g_mid_l
      assign left_word = cell_word[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_mid_r
      assign right_word = cell_word[i+1];
    end

    always_comb begin
      cell_ctl[i].is_tail = (count == CNT_W'(i + 1));
      priority if (shift_right) begin
        cell_ctl[i].op = CELL_FROM_LEFT;
      end else if (shift_left) begin
        cell_ctl[i].op = CELL_FROM_RIGHT;
      end else if (load_back && (count == CNT_W'(i))) begin
        cell_ctl[i].op = CELL_LOAD;
      end else begin
        cell_ctl[i].op = CELL_HOLD;
      end
    end

    dq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .left_word (left_word),
      .right_word(right_word),
      .load_word (word_in),
      .word      (cell_word[i]),
      .tail_word (tail_word[i])
    );
  end

  assign rd_wide = 64'(rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    data_out    <= rd_wide[31:0];
    status      <= status_next;
    entry_count <= count_next;
    is_empty    <= (count_next == '0);
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !done)
    else $error("result without accepted word");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (entry_count == CNT_W'(CAPACITY)))
    else $error("full status while not full");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    done |-> (entry_count == count))
    else $error("reported count differs from stored count");
`endif

endmodule

@@ hw/rtl/dq_cell.sv @@
`timescale 1ns / 1ps

module dq_cell
  import dq_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic [DATA_WIDTH-1:0] left_word,
  input  logic [DATA_WIDTH-1:0] right_word,
  input  logic [DATA_WIDTH-1:0] load_word,
  output logic [DATA_WIDTH-1:0] word,
  output logic [DATA_WIDTH-1:0] tail_word
);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_HOLD:       word <= word;
      CELL_FROM_LEFT:  word <= left_word;
      CELL_FROM_RIGHT: word <= right_word;
      CELL_LOAD:       word <= load_word;
      default:         word <= word;
    endcase
  end

  assign tail_word = ctl.is_tail ? word : '0;

endmodule
